[rtl/core/dpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpm_pkg: shared widths, register map and types for the motor mixer
// Field widths of the sample and duty beats, gain format and register codes.
// ----------------------------------------------------------------------------
package dpm_pkg;

	// Beat field widths
	localparam int POS_W   = 13;  // line position, unsigned
	localparam int DSPD_W  = 12;  // desired speed, unsigned Q4.8
	localparam int MSPD_W  = 13;  // measured speed, signed Q4.8
	localparam int DUTY_W  = 8;   // pin duty

	// Internal error widths
	localparam int LE_W    = 13;  // line error, -3500..3500
	localparam int LD_W    = 14;  // line error delta
	localparam int SE_W    = 14;  // speed error, -4095..8191
	localparam int SD_W    = 15;  // speed error delta

	// Gains and products
	localparam int GAIN_W  = 16;  // unsigned Q8.8
	localparam int STEER_W = 32;  // kp*le + kd*ld
	localparam int FRAC_W  = 16;  // drive scale 2^16
	localparam int STEER_SH = 8;  // steering is scaled by 2^8

	localparam logic [POS_W-1:0] LINE_MAX    = POS_W'(7000);
	localparam logic signed [LE_W:0] LINE_CENTRE = (LE_W+1)'(3500);
	localparam logic [DUTY_W-1:0] DUTY_FULL  = '1;

	localparam int DEF_INTEGRAL_TAPS = 9;

	// APB register map
	localparam int REG_NUM  = 6;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LINE_KP  = 3'd0,
		REG_LINE_KD  = 3'd1,
		REG_SPEED_KP = 3'd2,
		REG_SPEED_KD = 3'd3,
		REG_SPEED_KI = 3'd4,
		REG_MAX_PWM  = 3'd5
	} reg_idx_t;

	// Forward and reverse duty of one motor
	typedef struct packed {
		logic [DUTY_W-1:0] fwd;
		logic [DUTY_W-1:0] rev;
	} duty_pair_t;

endpackage
`default_nettype wire

[rtl/core/dual_pd_pid_motor_mixer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_pd_pid_motor_mixer: differential-drive steering and speed mixer
// PD steering on the line error, windowed PID on the speed error, mixed into
// forward and reverse pin duties for the left and right motors.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | beat contents
//  --------+-----------+------------------------+-------------------------------
//  sample  | in        | in_valid / in_stall    | line_position, desired_speed,
//          |           |                        | measured_speed
//  duty    | out       | out_valid / out_stall  | left/right forward/reverse duty
//  config  | in        | APB psel/penable/...   | gains and max_pwm
//
//  One sample beat is taken every cycle while in_stall is low; its duty beat
//  passes the error, product and mix/clamp registers in that order before it
//  is presented on the duty channel.
//  The pipeline holds up to three beats; a stalled stage holds and the stall
//  propagates back to in_stall only when every stage ahead of it is full.
//  Reset clears the control state, error history and integral window at once;
//  the integral ring needs no clearing pass because each slot has a valid bit.
//  Write configuration only while the pipeline is empty.
//
module dual_pd_pid_motor_mixer #(
	parameter int INTEGRAL_TAPS = dpm_pkg::DEF_INTEGRAL_TAPS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	// sample channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [dpm_pkg::POS_W-1:0]    line_position,
	input  wire logic [dpm_pkg::DSPD_W-1:0]   desired_speed,
	input  wire logic signed [dpm_pkg::MSPD_W-1:0] measured_speed,

	// duty channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [dpm_pkg::DUTY_W-1:0]        left_forward_duty,
	output logic [dpm_pkg::DUTY_W-1:0]        left_reverse_duty,
	output logic [dpm_pkg::DUTY_W-1:0]        right_forward_duty,
	output logic [dpm_pkg::DUTY_W-1:0]        right_reverse_duty,

	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dpm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [dpm_pkg::PDATA_W-1:0]  pwdata,
	output logic [dpm_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	import dpm_pkg::*;

	// Ring index and window sum widths follow the tap count
	localparam int IDX_W   = (INTEGRAL_TAPS > 1) ? $clog2(INTEGRAL_TAPS) : 1;
	localparam int SUM_W   = SE_W + $clog2(INTEGRAL_TAPS);
	localparam int SPD_MAXW = (SUM_W > SD_W) ? SUM_W : SD_W;
	localparam int SPEED_W = SPD_MAXW + GAIN_W + 3;
	localparam int SSH_W   = STEER_W + STEER_SH;
	localparam int DRIVE_W = ((SPEED_W > SSH_W) ? SPEED_W : SSH_W) + 1;
	localparam int MAG_W   = DRIVE_W - FRAC_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(INTEGRAL_TAPS - 1);

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	logic [GAIN_W-1:0] line_kp_q, line_kd_q, speed_kp_q, speed_kd_q, speed_ki_q;
	logic [DUTY_W-1:0] max_pwm_q;
	logic              cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_kp_q  <= '0;
			line_kd_q  <= '0;
			speed_kp_q <= '0;
			speed_kd_q <= '0;
			speed_ki_q <= '0;
			max_pwm_q  <= DUTY_FULL;
		end else if (cfg_wr) begin
			// Unmapped addresses drop the write
			case (cfg_idx)
				REG_LINE_KP:  line_kp_q  <= pwdata[GAIN_W-1:0];
				REG_LINE_KD:  line_kd_q  <= pwdata[GAIN_W-1:0];
				REG_SPEED_KP: speed_kp_q <= pwdata[GAIN_W-1:0];
				REG_SPEED_KD: speed_kd_q <= pwdata[GAIN_W-1:0];
				REG_SPEED_KI: speed_ki_q <= pwdata[GAIN_W-1:0];
				REG_MAX_PWM:  max_pwm_q  <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_LINE_KP:  prdata = PDATA_W'(line_kp_q);
			REG_LINE_KD:  prdata = PDATA_W'(line_kd_q);
			REG_SPEED_KP: prdata = PDATA_W'(speed_kp_q);
			REG_SPEED_KD: prdata = PDATA_W'(speed_kd_q);
			REG_SPEED_KI: prdata = PDATA_W'(speed_ki_q);
			REG_MAX_PWM:  prdata = PDATA_W'(max_pwm_q);
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Pipeline flow control: a stage advances when it is empty or the stage
	// ahead of it advances.
	// ------------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;
	logic in_acc;

	assign adv_s3   = !valid_s3 || !out_stall;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// ------------------------------------------------------------------------
	// Error stage: line and speed errors, their deltas and the window sum.
	// The controller history advances on every accepted sample beat.
	// ------------------------------------------------------------------------
	logic [POS_W-1:0]         pos_sat;
	logic signed [LE_W-1:0]   le;
	logic signed [LD_W-1:0]   ld;
	logic signed [SE_W-1:0]   se;
	logic signed [SD_W-1:0]   sd;
	logic signed [SUM_W-1:0]  sum_nxt;
	logic [IDX_W-1:0]         slot_nxt;

	logic signed [LE_W-1:0]   prev_line_error_q;
	logic signed [SE_W-1:0]   prev_speed_error_q;
	logic signed [SUM_W-1:0]  error_window_sum_q;
	logic [IDX_W-1:0]         ring_position_q;
	logic signed [SE_W-1:0]   oldest_q;      // ring entry that the next beat evicts
	logic [INTEGRAL_TAPS-1:0] ring_vld_q;
	logic signed [SE_W-1:0]   ring_mem [INTEGRAL_TAPS];

	always_comb begin
		// Saturate the position so the line error stays in range
		pos_sat  = (line_position > LINE_MAX) ? LINE_MAX : line_position;
		le       = LE_W'(LINE_CENTRE - $signed({1'b0, pos_sat}));
		ld       = LD_W'(le) - LD_W'(prev_line_error_q);
		se       = $signed(SE_W'({1'b0, desired_speed})) - SE_W'(measured_speed);
		sd       = SD_W'(se) - SD_W'(prev_speed_error_q);
		sum_nxt  = error_window_sum_q - SUM_W'(oldest_q) + SUM_W'(se);
		slot_nxt = (ring_position_q == LAST_SLOT) ? '0 : ring_position_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_line_error_q  <= '0;
			prev_speed_error_q <= '0;
			error_window_sum_q <= '0;
			ring_position_q    <= '0;
			oldest_q           <= '0;
			ring_vld_q         <= '0;
		end else if (in_acc) begin
			prev_line_error_q  <= le;
			prev_speed_error_q <= se;
			error_window_sum_q <= sum_nxt;
			ring_position_q    <= slot_nxt;
			ring_vld_q[ring_position_q] <= 1'b1;
			// Prefetch the next victim; a one-tap ring evicts what it writes now
			if (slot_nxt == ring_position_q) begin
				oldest_q <= se;
			end else if (ring_vld_q[slot_nxt]) begin
				oldest_q <= ring_mem[slot_nxt];
			end else begin
				oldest_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ring_mem[ring_position_q] <= se;
		end
	end

	logic signed [LE_W-1:0]  le_s1;
	logic signed [LD_W-1:0]  ld_s1;
	logic signed [SE_W-1:0]  se_s1;
	logic signed [SD_W-1:0]  sd_s1;
	logic signed [SUM_W-1:0] sum_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			le_s1  <= le;
			ld_s1  <= ld;
			se_s1  <= se;
			sd_s1  <= sd;
			sum_s1 <= sum_nxt;
		end
	end

	// ------------------------------------------------------------------------
	// Product stage: steering PD and speed PID
	// ------------------------------------------------------------------------
	logic signed [STEER_W-1:0] steer;
	logic signed [SPEED_W-1:0] speed;
	logic signed [STEER_W-1:0] steer_s2;
	logic signed [SPEED_W-1:0] speed_s2;

	always_comb begin
		steer = STEER_W'($signed({1'b0, line_kp_q}) * le_s1)
		      + STEER_W'($signed({1'b0, line_kd_q}) * ld_s1);
		speed = SPEED_W'($signed({1'b0, speed_kp_q}) * se_s1)
		      + SPEED_W'($signed({1'b0, speed_kd_q}) * sd_s1)
		      + SPEED_W'($signed({1'b0, speed_ki_q}) * sum_s1);
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			steer_s2 <= steer;
			speed_s2 <= speed;
		end
	end

	// ------------------------------------------------------------------------
	// Mix and clamp stage
	// ------------------------------------------------------------------------
	function automatic duty_pair_t drive_to_duty(
		input logic signed [DRIVE_W-1:0] v,
		input logic [DUTY_W-1:0]         lim
	);
		logic [DRIVE_W-1:0] mag;
		logic [MAG_W-1:0]   d;
		duty_pair_t         r;
		mag = v[DRIVE_W-1] ? DRIVE_W'(-v) : DRIVE_W'(v);
		d   = mag[DRIVE_W-1:FRAC_W];
		r   = '0;
		if (v[DRIVE_W-1]) begin
			r.rev = (d > MAG_W'(DUTY_FULL)) ? DUTY_FULL : d[DUTY_W-1:0];
		end else begin
			r.fwd = (d > MAG_W'(lim)) ? lim : d[DUTY_W-1:0];
		end
		return r;
	endfunction

	logic signed [DRIVE_W-1:0] steer_sh;
	logic signed [DRIVE_W-1:0] left_drv, right_drv;
	duty_pair_t                left_duty, right_duty;
	duty_pair_t                left_s3, right_s3;

	always_comb begin
		steer_sh   = DRIVE_W'(steer_s2) <<< STEER_SH;
		left_drv   = DRIVE_W'(speed_s2) + steer_sh;
		right_drv  = DRIVE_W'(speed_s2) - steer_sh;
		left_duty  = drive_to_duty(left_drv, max_pwm_q);
		right_duty = drive_to_duty(right_drv, max_pwm_q);
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			left_s3  <= left_duty;
			right_s3 <= right_duty;
		end
	end

	assign out_valid          = valid_s3;
	assign left_forward_duty  = left_s3.fwd;
	assign left_reverse_duty  = left_s3.rev;
	assign right_forward_duty = right_s3.fwd;
	assign right_reverse_duty = right_s3.rev;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_ring_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		ring_position_q <= LAST_SLOT)
		else $error("ring position beyond last tap");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((left_forward_duty == '0) || (left_reverse_duty == '0))
		           && ((right_forward_duty == '0) || (right_reverse_duty == '0)))
		else $error("motor driven forward and reverse at once");

	a_fwd_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_forward_duty <= max_pwm_q) && (right_forward_duty <= max_pwm_q))
		else $error("forward duty above max_pwm");

	a_ring_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (ring_position_q != $past(ring_position_q)) || (INTEGRAL_TAPS == 1))
		else $error("ring position did not advance on accepted beat");

endmodule
`default_nettype wire
